// File: design/rvb_pkg.sv
// ----------------------------------------------------------------------------
// rvb_pkg
// Shared types, register map and delay helpers for the Schroeder reverb.
// ----------------------------------------------------------------------------
package rvb_pkg;

    // Default sizing
    localparam int unsigned HISTORY_DEPTH_DEF = 4096;
    localparam int unsigned COMB_DEPTH_DEF    = 2048;
    localparam int unsigned ALLPASS_DEPTH_DEF = 256;
    localparam int unsigned TAPS_DEF          = 10;
    localparam int unsigned SAMPLE_RATE_DEF   = 44100;
    localparam int unsigned INNER_WIDTH_DEF   = 24;

    // Configuration port
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;
    localparam int GAIN_W     = 15;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_COMB_A  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COMB_B  = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COMB_C  = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COMB_D  = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_AP_GAIN = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DRY     = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_EARLY   = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_REVERB  = 4'd7;

    // Register reset values, Q0.15
    localparam logic [GAIN_W-1:0] RST_COMB_A  = 15'd28554;
    localparam logic [GAIN_W-1:0] RST_COMB_B  = 15'd28927;
    localparam logic [GAIN_W-1:0] RST_COMB_C  = 15'd29211;
    localparam logic [GAIN_W-1:0] RST_COMB_D  = 15'd29528;
    localparam logic [GAIN_W-1:0] RST_AP_GAIN = 15'd22938;
    localparam logic [GAIN_W-1:0] RST_LEVEL   = 15'd9830;

    // Line delays in microseconds
    localparam int unsigned COMB_US [4] = '{39850, 36100, 33270, 30150};
    localparam int unsigned AP_US   [2] = '{5000, 1700};
    localparam int unsigned TAP_US_BASE = 20000;
    localparam int unsigned TAP_US_STEP = 8000;

    // Configuration seen by the datapath
    typedef struct packed {
        logic [3:0][GAIN_W-1:0] comb_gain;
        logic [GAIN_W-1:0]      ap_gain;
        logic [GAIN_W-1:0]      dry_level;
        logic [GAIN_W-1:0]      early_level;
        logic [GAIN_W-1:0]      reverb_level;
    } t_cfg;

    // Delay in samples, rounded, clamped to [1, depth-1]
    function automatic int unsigned delay_of(input int unsigned rate,
                                             input int unsigned us,
                                             input int unsigned depth);
        longint unsigned d;
        d = (longint'(rate) * longint'(us) + 64'd500000) / 64'd1000000;
        if (d < 1) d = 1;
        if (d > depth - 1) d = depth - 1;
        return int'(d);
    endfunction

endpackage

// File: design/rvb_cfg.sv
// ----------------------------------------------------------------------------
// rvb_cfg
// Configuration register file: gains and mix levels.
// ----------------------------------------------------------------------------
module rvb_cfg import rvb_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    // Register writes; indexes past the map are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.comb_gain[0] <= RST_COMB_A;
            r_cfg.comb_gain[1] <= RST_COMB_B;
            r_cfg.comb_gain[2] <= RST_COMB_C;
            r_cfg.comb_gain[3] <= RST_COMB_D;
            r_cfg.ap_gain      <= RST_AP_GAIN;
            r_cfg.dry_level    <= RST_LEVEL;
            r_cfg.early_level  <= RST_LEVEL;
            r_cfg.reverb_level <= RST_LEVEL;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_COMB_A:  r_cfg.comb_gain[0] <= i_cfg_data[GAIN_W-1:0];
                REG_COMB_B:  r_cfg.comb_gain[1] <= i_cfg_data[GAIN_W-1:0];
                REG_COMB_C:  r_cfg.comb_gain[2] <= i_cfg_data[GAIN_W-1:0];
                REG_COMB_D:  r_cfg.comb_gain[3] <= i_cfg_data[GAIN_W-1:0];
                REG_AP_GAIN: r_cfg.ap_gain      <= i_cfg_data[GAIN_W-1:0];
                REG_DRY:     r_cfg.dry_level    <= i_cfg_data[GAIN_W-1:0];
                REG_EARLY:   r_cfg.early_level  <= i_cfg_data[GAIN_W-1:0];
                REG_REVERB:  r_cfg.reverb_level <= i_cfg_data[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

endmodule

// File: design/rvb_mul.sv
// ----------------------------------------------------------------------------
// rvb_mul
// Shared registered multiplier: unsigned Q0.15 gain times signed value.
// ----------------------------------------------------------------------------
module rvb_mul import rvb_pkg::*; #(
    parameter int IW = INNER_WIDTH_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic [GAIN_W-1:0]       i_gain,
    input  logic signed [IW:0]      i_val,
    output logic signed [IW+16:0]   o_prod
);

    logic signed [IW+16:0] r_prod;

    assign o_prod = r_prod;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= $signed({1'b0, i_gain}) * i_val;
        end
    end

endmodule

// File: design/rvb_core.sv
// ----------------------------------------------------------------------------
// rvb_core
// Sequencer, delay memories and accumulator around the shared multiplier.
// ----------------------------------------------------------------------------
module rvb_core import rvb_pkg::*; #(
    parameter int HD          = HISTORY_DEPTH_DEF,
    parameter int CD          = COMB_DEPTH_DEF,
    parameter int AD          = ALLPASS_DEPTH_DEF,
    parameter int TAPS        = TAPS_DEF,
    parameter int SAMPLE_RATE = SAMPLE_RATE_DEF,
    parameter int IW          = INNER_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [15:0] i_sample,
    input  logic               i_present,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [15:0] o_sample,
    output logic               o_sat,
    output logic               o_clip
);

    localparam int HAW     = $clog2(HD);
    localparam int CAW     = $clog2(CD);
    localparam int AAW     = $clog2(AD);
    localparam int MAXD    = (HD > CD) ? ((HD > AD) ? HD : AD) : ((CD > AD) ? CD : AD);
    localparam int FW      = $clog2(MAXD + 1);
    localparam int PW      = IW + 17;
    localparam int ACC_W   = IW + 19;
    localparam int TCW     = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int CNTW    = (TCW > 2) ? TCW : 2;
    localparam int TAP_DEN = 10 * TAPS;

    localparam logic signed [ACC_W-1:0] IW_MAX  = ACC_W'((64'sd1 <<< (IW - 1)) - 1);
    localparam logic signed [ACC_W-1:0] IW_MIN  = -IW_MAX - 1;
    localparam logic signed [ACC_W-1:0] CLIP_HI = ACC_W'(64'sd1 <<< 30);
    localparam logic signed [ACC_W-1:0] CLIP_LO = -CLIP_HI;
    localparam logic signed [ACC_W-1:0] S16_MAX = ACC_W'(32767);
    localparam logic signed [ACC_W-1:0] S16_MIN = -S16_MAX - 1;
    localparam logic signed [ACC_W-1:0] HALF    = ACC_W'(16384);

    // Constant tables built at elaboration
    function automatic logic [TAPS*HAW-1:0] tap_delays();
        logic [TAPS*HAW-1:0] t;
        t = '0;
        for (int j = 0; j < TAPS; j++)
            t[j*HAW +: HAW] = HAW'(delay_of(SAMPLE_RATE, TAP_US_BASE + TAP_US_STEP * j, HD));
        return t;
    endfunction

    function automatic logic [TAPS*GAIN_W-1:0] tap_gains();
        logic [TAPS*GAIN_W-1:0] t;
        longint g;
        t = '0;
        for (int j = 0; j < TAPS; j++) begin
            g = (64'sd32768 * (6 * TAPS - 3 * j) + 5 * TAPS) / TAP_DEN;
            t[j*GAIN_W +: GAIN_W] = GAIN_W'(g);
        end
        return t;
    endfunction

    function automatic logic [4*HAW-1:0] comb_hist_delays();
        logic [4*HAW-1:0] t;
        for (int j = 0; j < 4; j++)
            t[j*HAW +: HAW] = HAW'(delay_of(SAMPLE_RATE, COMB_US[j], HD));
        return t;
    endfunction

    function automatic logic [4*CAW-1:0] comb_delays();
        logic [4*CAW-1:0] t;
        for (int j = 0; j < 4; j++)
            t[j*CAW +: CAW] = CAW'(delay_of(SAMPLE_RATE, COMB_US[j], CD));
        return t;
    endfunction

    function automatic logic [2*AAW-1:0] ap_delays();
        logic [2*AAW-1:0] t;
        for (int j = 0; j < 2; j++)
            t[j*AAW +: AAW] = AAW'(delay_of(SAMPLE_RATE, AP_US[j], AD));
        return t;
    endfunction

    localparam logic [TAPS*HAW-1:0]    TAP_D  = tap_delays();
    localparam logic [TAPS*GAIN_W-1:0] TAP_G  = tap_gains();
    localparam logic [4*HAW-1:0]       COMB_H = comb_hist_delays();
    localparam logic [4*CAW-1:0]       COMB_D = comb_delays();
    localparam logic [2*AAW-1:0]       AP_D   = ap_delays();

    // Round a Q15 product half up
    function automatic logic signed [ACC_W-1:0] rnd15(input logic signed [ACC_W-1:0] v);
        return (v + HALF) >>> 15;
    endfunction

    // Saturate to the inner width
    function automatic logic signed [IW-1:0] sat_iw(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] s;
        s = v;
        if (v > IW_MAX) s = IW_MAX;
        if (v < IW_MIN) s = IW_MIN;
        return IW'(s);
    endfunction

    typedef enum logic [4:0] {
        S_IDLE, S_TAP_RD, S_TAP_MUL, S_EARLY, S_EARLY2,
        S_CMB_RD, S_CMB_MUL, S_CMB_ADD, S_AP_START,
        S_AP_RD, S_AP_MUL, S_AP_ADD,
        S_MIX0, S_MIX1, S_MIX2, S_MIX3, S_MIX4, S_DONE
    } t_state;

    t_state                   r_state;
    logic [CNTW-1:0]          r_cnt;
    logic [HAW-1:0]           r_wp;
    logic [CAW-1:0]           r_cp;
    logic [AAW-1:0]           r_ap;
    logic [FW-1:0]            r_fill;
    logic signed [15:0]       r_x;
    logic signed [ACC_W-1:0]  r_acc;
    logic                     r_pend;
    logic signed [IW-1:0]     r_early;
    logic                     r_clip;
    logic signed [IW+1:0]     r_rsum;
    logic signed [IW-1:0]     r_v;
    logic signed [IW-1:0]     r_xd;
    logic signed [15:0]       r_res;
    logic                     r_res_sat;
    logic                     r_ovld;
    logic signed [15:0]       r_osample;
    logic                     r_osat;
    logic                     r_oclip;

    // Delay memories
    logic signed [15:0]    r_hist_mem [HD];
    logic signed [IW-1:0]  r_comb_mem [4][CD];
    logic signed [IW-1:0]  r_apx_mem  [2][AD];
    logic signed [IW-1:0]  r_apy_mem  [2][AD];
    logic signed [15:0]    r_hist_rd;
    logic signed [IW-1:0]  r_comb_rd;
    logic signed [IW-1:0]  r_apx_rd;
    logic signed [IW-1:0]  r_apy_rd;
    logic                  r_hok;
    logic                  r_cok;
    logic                  r_aok;

    logic [HAW-1:0]        h_d;
    logic [HAW-1:0]        h_ra;
    logic [CAW-1:0]        c_d;
    logic [CAW-1:0]        c_ra;
    logic [AAW-1:0]        a_d;
    logic [AAW-1:0]        a_ra;
    logic                  m_en;
    logic [GAIN_W-1:0]     m_gain;
    logic signed [IW:0]    m_val;
    logic signed [PW-1:0]  prod;
    logic signed [IW-1:0]  step_y;
    logic signed [ACC_W-1:0] mix_r;

    rvb_mul #(.IW(IW)) u_mul (
        .i_clk  (i_clk),
        .i_en   (m_en),
        .i_gain (m_gain),
        .i_val  (m_val),
        .o_prod (prod)
    );

    // Read addresses: position minus delay, wrapped
    always_comb begin
        if (r_state == S_TAP_RD) h_d = TAP_D[r_cnt*HAW +: HAW];
        else                     h_d = COMB_H[r_cnt[1:0]*HAW +: HAW];
        c_d = COMB_D[r_cnt[1:0]*CAW +: CAW];
        a_d = AP_D[r_cnt[0]*AAW +: AAW];
        h_ra = (r_wp >= h_d) ? (r_wp - h_d)
                             : HAW'({1'b0, r_wp} + (HAW+1)'(HD) - {1'b0, h_d});
        c_ra = (r_cp >= c_d) ? (r_cp - c_d)
                             : CAW'({1'b0, r_cp} + (CAW+1)'(CD) - {1'b0, c_d});
        a_ra = (r_ap >= a_d) ? (r_ap - a_d)
                             : AAW'({1'b0, r_ap} + (AAW+1)'(AD) - {1'b0, a_d});
    end

    // Multiplier operand select
    always_comb begin
        m_en   = 1'b1;
        m_gain = '0;
        m_val  = '0;
        case (r_state)
            S_TAP_MUL: begin
                m_gain = TAP_G[r_cnt*GAIN_W +: GAIN_W];
                m_val  = r_hok ? (IW+1)'(r_hist_rd) : '0;
            end
            S_CMB_MUL: begin
                m_gain = i_cfg.comb_gain[r_cnt[1:0]];
                m_val  = r_cok ? (IW+1)'(r_comb_rd) : '0;
            end
            S_AP_MUL: begin
                m_gain = i_cfg.ap_gain;
                m_val  = (r_aok ? (IW+1)'(r_apy_rd) : '0) - (IW+1)'(r_v);
            end
            S_MIX0: begin
                m_gain = i_cfg.dry_level;
                m_val  = (IW+1)'(r_x);
            end
            S_MIX1: begin
                m_gain = i_cfg.early_level;
                m_val  = (IW+1)'(r_early);
            end
            S_MIX2: begin
                m_gain = i_cfg.reverb_level;
                m_val  = (IW+1)'(r_v);
            end
            default: m_en = 1'b0;
        endcase
    end

    // Line update: delayed input plus rounded feedback product
    assign step_y = sat_iw(ACC_W'(r_xd) + rnd15(ACC_W'(prod)));
    assign mix_r  = rnd15(r_acc);

    // History memory
    always_ff @(posedge i_clk) begin
        if (r_state == S_MIX4) r_hist_mem[r_wp] <= r_x;
        r_hist_rd <= r_hist_mem[h_ra];
        r_hok     <= (r_fill >= FW'(h_d));
    end

    // Comb memory
    always_ff @(posedge i_clk) begin
        if (r_state == S_CMB_ADD) r_comb_mem[r_cnt[1:0]][r_cp] <= step_y;
        r_comb_rd <= r_comb_mem[r_cnt[1:0]][c_ra];
        r_cok     <= (r_fill >= FW'(c_d));
    end

    // Allpass memories: input line and output line
    always_ff @(posedge i_clk) begin
        if (r_state == S_AP_ADD) begin
            r_apx_mem[r_cnt[0]][r_ap] <= r_v;
            r_apy_mem[r_cnt[0]][r_ap] <= step_y;
        end
        r_apx_rd <= r_apx_mem[r_cnt[0]][a_ra];
        r_apy_rd <= r_apy_mem[r_cnt[0]][a_ra];
        r_aok    <= (r_fill >= FW'(a_d));
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_wp    <= '0;
            r_cp    <= '0;
            r_ap    <= '0;
            r_fill  <= '0;
            r_pend  <= 1'b0;
            r_ovld  <= 1'b0;
        end else begin
            // Output register drains here except when S_DONE refills it
            if (r_ovld && i_ready && (r_state != S_DONE)) r_ovld <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_x     <= i_present ? i_sample : '0;
                        r_acc   <= '0;
                        r_pend  <= 1'b0;
                        r_cnt   <= '0;
                        r_state <= S_TAP_RD;
                    end
                end
                S_TAP_RD: begin
                    if (r_pend) r_acc <= r_acc + ACC_W'(prod);
                    r_state <= S_TAP_MUL;
                end
                S_TAP_MUL: begin
                    r_pend <= 1'b1;
                    if (r_cnt == CNTW'(TAPS - 1)) begin
                        r_state <= S_EARLY;
                    end else begin
                        r_cnt   <= r_cnt + 1'b1;
                        r_state <= S_TAP_RD;
                    end
                end
                S_EARLY: begin
                    r_acc   <= r_acc + ACC_W'(prod);
                    r_state <= S_EARLY2;
                end
                S_EARLY2: begin
                    r_clip  <= (r_acc >= CLIP_HI) || (r_acc <= CLIP_LO);
                    r_early <= sat_iw(rnd15(r_acc));
                    r_rsum  <= '0;
                    r_cnt   <= '0;
                    r_state <= S_CMB_RD;
                end
                S_CMB_RD: r_state <= S_CMB_MUL;
                S_CMB_MUL: begin
                    r_xd    <= r_hok ? IW'(r_hist_rd) : '0;
                    r_state <= S_CMB_ADD;
                end
                S_CMB_ADD: begin
                    r_rsum <= r_rsum + (IW+2)'(step_y);
                    r_cnt  <= r_cnt + 1'b1;
                    if (r_cnt[1:0] == 2'd3) r_state <= S_AP_START;
                    else                    r_state <= S_CMB_RD;
                end
                S_AP_START: begin
                    r_v     <= sat_iw(ACC_W'(r_rsum));
                    r_cnt   <= '0;
                    r_state <= S_AP_RD;
                end
                S_AP_RD: r_state <= S_AP_MUL;
                S_AP_MUL: begin
                    r_xd    <= r_aok ? r_apx_rd : '0;
                    r_state <= S_AP_ADD;
                end
                S_AP_ADD: begin
                    r_v   <= step_y;
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt[0]) r_state <= S_MIX0;
                    else          r_state <= S_AP_RD;
                end
                S_MIX0: r_state <= S_MIX1;
                S_MIX1: begin
                    r_acc   <= ACC_W'(prod);
                    r_state <= S_MIX2;
                end
                S_MIX2: begin
                    r_acc   <= r_acc + ACC_W'(prod);
                    r_state <= S_MIX3;
                end
                S_MIX3: begin
                    r_acc   <= r_acc + ACC_W'(prod);
                    r_state <= S_MIX4;
                end
                S_MIX4: begin
                    // Final saturation, advance all line positions
                    if (mix_r > S16_MAX) begin
                        r_res     <= 16'sh7FFF;
                        r_res_sat <= 1'b1;
                    end else if (mix_r < S16_MIN) begin
                        r_res     <= 16'sh8000;
                        r_res_sat <= 1'b1;
                    end else begin
                        r_res     <= 16'(mix_r);
                        r_res_sat <= 1'b0;
                    end
                    r_wp <= (r_wp == HAW'(HD - 1)) ? '0 : r_wp + 1'b1;
                    r_cp <= (r_cp == CAW'(CD - 1)) ? '0 : r_cp + 1'b1;
                    r_ap <= (r_ap == AAW'(AD - 1)) ? '0 : r_ap + 1'b1;
                    if (r_fill != FW'(MAXD)) r_fill <= r_fill + 1'b1;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    // Wait for the output register to free up
                    if (!r_ovld || i_ready) begin
                        r_ovld    <= 1'b1;
                        r_osample <= r_res;
                        r_osat    <= r_res_sat;
                        r_oclip   <= r_clip;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_ready  = (r_state == S_IDLE);
    assign o_valid  = r_ovld;
    assign o_sample = r_osample;
    assign o_sat    = r_osat;
    assign o_clip   = r_oclip;

endmodule

// File: design/schroeder_reverb_top.sv
// ----------------------------------------------------------------------------
// schroeder_reverb_top
// Schroeder reverb: early taps, four combs, two allpasses, dry/early/wet mix.
// ----------------------------------------------------------------------------
// One sample item in gives one sample item out. The block holds o_ready low
// while it works on an item and takes no new item until the last one is in
// the output register. Its pace is set by the single shared multiplier that
// handles every tap, comb feedback, allpass and mix product in turn; the tap,
// comb and allpass products each follow a registered memory read. A finished
// item waits in an output register, so the next item can be accepted before
// it is taken. Delay lines start out reading as zero through a fill count; no
// clearing pass is needed. Configuration writes are taken every cycle and
// belong to idle periods.
module schroeder_reverb_top import rvb_pkg::*; #(
    parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
    parameter int COMB_DEPTH    = COMB_DEPTH_DEF,
    parameter int ALLPASS_DEPTH = ALLPASS_DEPTH_DEF,
    parameter int TAPS          = TAPS_DEF,
    parameter int SAMPLE_RATE   = SAMPLE_RATE_DEF,
    parameter int INNER_WIDTH   = INNER_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic signed [15:0]    i_in_sample,
    input  logic                  i_input_present,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic signed [15:0]    o_out_sample,
    output logic                  o_out_saturated,
    output logic                  o_early_clipped
);

    t_cfg cfg;

    rvb_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    rvb_core #(
        .HD          (HISTORY_DEPTH),
        .CD          (COMB_DEPTH),
        .AD          (ALLPASS_DEPTH),
        .TAPS        (TAPS),
        .SAMPLE_RATE (SAMPLE_RATE),
        .IW          (INNER_WIDTH)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_sample  (i_in_sample),
        .i_present (i_input_present),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_sample  (o_out_sample),
        .o_sat     (o_out_saturated),
        .o_clip    (o_early_clipped)
    );

endmodule

// File: design/rvb_checker.sv
// ----------------------------------------------------------------------------
// rvb_checker
// Port-level checks on the reverb top, attached by bind.
// ----------------------------------------------------------------------------
module rvb_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_ready,
    input logic               o_valid,
    input logic               i_ready,
    input logic signed [15:0] o_out_sample,
    input logic               o_out_saturated
);

    // Stalled result holds its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_out_sample))
        else $error("result changed while stalled");

    // Block goes busy after taking an item
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("ready stayed high after accept");

    // Saturation flag only with a rail value
    a_sat_rail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_out_saturated |->
            (o_out_sample == 16'sh7FFF) || (o_out_sample == 16'sh8000))
        else $error("saturation flag without rail value");

    // No result right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_valid)
        else $error("result valid after reset");

endmodule

bind schroeder_reverb_top rvb_checker u_rvb_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_valid         (i_valid),
    .o_ready         (o_ready),
    .o_valid         (o_valid),
    .i_ready         (i_ready),
    .o_out_sample    (o_out_sample),
    .o_out_saturated (o_out_saturated)
);
